### rtl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Constants for the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

   localparam int unsigned CFG_BITS   = 16;
   localparam int unsigned INDEX_BITS = 8;
   localparam int unsigned COUNT_BITS = 3;

   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Register indexes on the configuration port.
   localparam index_type REG_LONG_PRESS = 8'd0;
   localparam index_type REG_CLICK_MIN  = 8'd1;
   localparam index_type REG_CLICK_MAX  = 8'd2;
   localparam index_type REG_SETTLE     = 8'd3;

   // Register reset values.
   localparam cfg_type LONG_RESET   = 16'd850;
   localparam cfg_type CMIN_RESET   = 16'd50;
   localparam cfg_type CMAX_RESET   = 16'd300;
   localparam cfg_type SETTLE_RESET = 16'd300;

   // Click counting limits.
   localparam count_type COUNT_MAX  = 3'd7;
   localparam count_type DOUBLE_MIN = 3'd2;
   localparam count_type DOUBLE_MAX = 3'd5;

endpackage

### rtl/button_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Classifies press and release ticks into single, double and long presses.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  req       req_valid / req_ready  req_press_event, req_release_event
//  rsp       rsp_valid / rsp_ready  rsp_single_click, rsp_double_click,
//                                   rsp_long_press
//  csr       csr_valid / csr_ready  csr_index, csr_data
//
// Every req beat yields one rsp beat in the next cycle; the state update and
// the result come from chained compares on the tick counter and stamps.
// A new beat is taken every cycle as long as the result register is empty or
// drained in the same cycle, so the sustained rate is one tick per cycle.
// Synchronous reset clears the counter, stamps, count and result valid flag
// and loads the register defaults. csr_ready is always high.
// ----------------------------------------------------------------------------
module button_gesture_classifier
   import bgc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,

   input  logic            req_valid,
   output logic            req_ready,
   input  logic            req_press_event,
   input  logic            req_release_event,

   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_single_click,
   output logic            rsp_double_click,
   output logic            rsp_long_press,

   input  logic            csr_valid,
   output logic            csr_ready,
   input  index_type       csr_index,
   input  cfg_type         csr_data
);

   typedef logic [TIME_BITS-1:0] time_type;

   cfg_type   long_ticks_ff, cmin_ticks_ff, cmax_ticks_ff, settle_ticks_ff;
   time_type  tick_time_ff, press_stamp_ff, release_stamp_ff;
   logic      long_armed_ff;
   count_type click_count_ff;

   logic      rsp_valid_ff, single_ff, double_ff, long_ff;

   time_type  press_stamp_in, release_stamp_in;
   logic      long_armed_in;
   count_type click_count_in;
   logic      single_in, double_in, long_in;

   time_type  held, hold, quiet;
   logic      accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      press_stamp_in   = press_stamp_ff;
      release_stamp_in = release_stamp_ff;
      long_armed_in    = long_armed_ff;
      click_count_in   = click_count_ff;
      single_in        = 1'b0;
      double_in        = 1'b0;
      long_in          = 1'b0;

      if (req_press_event) begin
         press_stamp_in = tick_time_ff;
         long_armed_in  = 1'b1;
      end

      held = tick_time_ff - press_stamp_in;
      if (long_armed_in && (held > time_type'(long_ticks_ff))) begin
         long_in       = 1'b1;
         long_armed_in = 1'b0;
      end

      // The hold at release is the same span as the one tested above.
      hold = held;
      if (req_release_event) begin
         release_stamp_in = tick_time_ff;
         if ((hold > time_type'(cmin_ticks_ff)) && (hold < time_type'(cmax_ticks_ff))) begin
            long_armed_in = 1'b0;
            if (click_count_in != COUNT_MAX) begin
               click_count_in = click_count_in + count_type'(1);
            end
         end
      end

      quiet = tick_time_ff - release_stamp_in;
      if (quiet >= time_type'(settle_ticks_ff)) begin
         single_in      = (click_count_in == count_type'(1));
         double_in      = (click_count_in >= DOUBLE_MIN) && (click_count_in <= DOUBLE_MAX);
         click_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_time_ff     <= '0;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         long_armed_ff    <= 1'b0;
         click_count_ff   <= '0;
      end else if (accept) begin
         tick_time_ff     <= tick_time_ff + time_type'(1);
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         long_armed_ff    <= long_armed_in;
         click_count_ff   <= click_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ticks_ff   <= LONG_RESET;
         cmin_ticks_ff   <= CMIN_RESET;
         cmax_ticks_ff   <= CMAX_RESET;
         settle_ticks_ff <= SETTLE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LONG_PRESS: long_ticks_ff   <= csr_data;
            REG_CLICK_MIN:  cmin_ticks_ff   <= csr_data;
            REG_CLICK_MAX:  cmax_ticks_ff   <= csr_data;
            REG_SETTLE:     settle_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         single_ff <= single_in;
         double_ff <= double_in;
         long_ff   <= long_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_single_click = single_ff;
   assign rsp_double_click = double_ff;
   assign rsp_long_press   = long_ff;

endmodule

### rtl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_port_checks
// Port-level checks for the button gesture classifier.
// ----------------------------------------------------------------------------
module bgc_port_checks (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_single_click,
   input logic rsp_double_click,
   input logic rsp_long_press,
   input logic csr_ready
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_single_click) && $stable(rsp_double_click)
         && $stable(rsp_long_press))
      else $error("result beat changed while stalled");

   // A single and a double click never come from the same classification.
   a_one_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_single_click && rsp_double_click))
      else $error("single and double click in one beat");

   // Every accepted tick produces a result on the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted tick gave no result beat");

   // Reset empties the result register and the input side is open.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready && csr_ready)
      else $error("block not idle after reset");

endmodule

bind button_gesture_classifier bgc_port_checks u_bgc_port_checks (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_single_click (rsp_single_click),
   .rsp_double_click (rsp_double_click),
   .rsp_long_press   (rsp_long_press),
   .csr_ready        (csr_ready)
);
